[rtl/tbt_pkg.sv]
package tbt_pkg;

	localparam int POS_W   = 32;
	localparam int TEX_W   = 20;
	localparam int EDGE_W  = POS_W + 1;
	localparam int DUV_W   = TEX_W + 1;
	localparam int OUT_W   = 16;
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = 1;

	// Q1.14 unit value, upper clamp of a normalized component
	localparam logic [16:0] UNIT_Q = 17'd16384;

	typedef logic signed [EDGE_W-1:0] edge_t;
	typedef logic signed [DUV_W-1:0]  duv_t;
	typedef logic signed [OUT_W-1:0]  comp_t;

	// one triangle, as handed from the front to the back
	typedef struct packed {
		edge_t e1_x;
		edge_t e1_y;
		edge_t e1_z;
		edge_t e2_x;
		edge_t e2_y;
		edge_t e2_z;
		duv_t  du1;
		duv_t  dv1;
		duv_t  du2;
		duv_t  dv2;
	} job_t;

endpackage

[rtl/tbt_front.sv]
module tbt_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        vtx_valid,
	output logic                        vtx_stall,
	input  logic signed [31:0]          position_x,
	input  logic signed [31:0]          position_y,
	input  logic signed [31:0]          position_z,
	input  logic signed [19:0]          tex_u,
	input  logic signed [19:0]          tex_v,
	input  logic                        q_full,
	output logic                        q_push,
	output tbt_pkg::job_t               q_data
);

	logic [1:0] phase_q;
	logic signed [31:0] p0x_q, p0y_q, p0z_q, p1x_q, p1y_q, p1z_q;
	logic signed [19:0] u0_q, v0_q, u1_q, v1_q;
	logic accept;

	assign vtx_stall = q_full;
	assign accept    = vtx_valid && !q_full;
	assign q_push    = accept && (phase_q == 2'd2);

	// edges relative to the first vertex, formed from the live third vertex
	always_comb begin
		q_data.e1_x = tbt_pkg::edge_t'(p1x_q) - tbt_pkg::edge_t'(p0x_q);
		q_data.e1_y = tbt_pkg::edge_t'(p1y_q) - tbt_pkg::edge_t'(p0y_q);
		q_data.e1_z = tbt_pkg::edge_t'(p1z_q) - tbt_pkg::edge_t'(p0z_q);
		q_data.e2_x = tbt_pkg::edge_t'(position_x) - tbt_pkg::edge_t'(p0x_q);
		q_data.e2_y = tbt_pkg::edge_t'(position_y) - tbt_pkg::edge_t'(p0y_q);
		q_data.e2_z = tbt_pkg::edge_t'(position_z) - tbt_pkg::edge_t'(p0z_q);
		q_data.du1  = tbt_pkg::duv_t'(u1_q) - tbt_pkg::duv_t'(u0_q);
		q_data.dv1  = tbt_pkg::duv_t'(v1_q) - tbt_pkg::duv_t'(v0_q);
		q_data.du2  = tbt_pkg::duv_t'(tex_u) - tbt_pkg::duv_t'(u0_q);
		q_data.dv2  = tbt_pkg::duv_t'(tex_v) - tbt_pkg::duv_t'(v0_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
		end else if (accept) begin
			if (phase_q == 2'd1) begin
				phase_q <= 2'd2;
			end else if (phase_q == 2'd2) begin
				phase_q <= 2'd0;
			end else begin
				phase_q <= 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && phase_q == 2'd1) begin
			p1x_q <= position_x;
			p1y_q <= position_y;
			p1z_q <= position_z;
			u1_q  <= tex_u;
			v1_q  <= tex_v;
		end else if (accept && phase_q != 2'd2) begin
			p0x_q <= position_x;
			p0y_q <= position_y;
			p0z_q <= position_z;
			u0_q  <= tex_u;
			v0_q  <= tex_v;
		end
	end

endmodule

[rtl/tbt_queue.sv]
module tbt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tbt_pkg::job_t   push_data,
	output logic            full,
	input  logic            pop,
	output logic            nonempty,
	output tbt_pkg::job_t   pop_data
);

	tbt_pkg::job_t mem_q [tbt_pkg::QDEPTH];
	logic [tbt_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [tbt_pkg::QPTR_W:0]   cnt_q;

	assign full     = (cnt_q == (tbt_pkg::QPTR_W+1)'(tbt_pkg::QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

[rtl/tbt_back.sv]
module tbt_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  tbt_pkg::job_t       job,
	output logic                job_pop,
	output logic                res_valid,
	input  logic                res_stall,
	output logic signed [15:0]  tangent_x,
	output logic signed [15:0]  tangent_y,
	output logic signed [15:0]  tangent_z,
	output logic signed [15:0]  bitangent_x,
	output logic signed [15:0]  bitangent_y,
	output logic signed [15:0]  bitangent_z,
	output logic                degenerate,
	output logic                last_of_triangle
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_MUL_END, ST_SETUP, ST_SCALE, ST_SQR, ST_SQR_END,
		ST_SQRT_INIT, ST_SQRT, ST_DIV_INIT, ST_DIV, ST_EMIT
	} state_t;

	localparam logic [4:0] DST_SQ = 5'd14;

	state_t state_q;
	tbt_pkg::job_t job_q;
	logic [4:0]  k_q;
	logic        vsel_q;
	logic [1:0]  comp_q;
	logic        degen_q;
	logic [1:0]  beat_q;
	logic signed [42:0] det_q;
	logic signed [55:0] tv_q [3];
	logic signed [55:0] bv_q [3];
	logic [55:0] mag_q [3];
	logic [2:0]  neg_q;
	logic [41:0] ssum_q;
	logic [63:0] rad_q, root_q, bit_q;
	logic [45:0] num_q;
	logic [47:0] dsh_q;
	logic [16:0] quo_q;
	logic [4:0]  dcnt_q;
	tbt_pkg::comp_t tres_q [3];
	tbt_pkg::comp_t bres_q [3];
	logic        res_valid_q;

	// shared multiplier, product registered
	logic signed [32:0] ma;
	logic signed [20:0] mb;
	logic signed [53:0] prod_s1;
	logic        pvalid_s1;
	logic [4:0]  pdst_s1;
	logic [3:0]  j;
	logic [1:0]  ji;
	tbt_pkg::edge_t e1_sel, e2_sel;

	assign j  = 4'(k_q - 5'd2);
	assign ji = j[3:2];

	always_comb begin
		unique case (ji)
			2'd0:    begin e1_sel = job_q.e1_x; e2_sel = job_q.e2_x; end
			2'd1:    begin e1_sel = job_q.e1_y; e2_sel = job_q.e2_y; end
			default: begin e1_sel = job_q.e1_z; e2_sel = job_q.e2_z; end
		endcase
		ma = '0;
		mb = '0;
		if (state_q == ST_SQR) begin
			ma = $signed({13'd0, mag_q[k_q[1:0]][19:0]});
			mb = $signed({1'b0, mag_q[k_q[1:0]][19:0]});
		end else if (k_q == 5'd0) begin
			ma = tbt_pkg::edge_t'(job_q.du1);
			mb = job_q.dv2;
		end else if (k_q == 5'd1) begin
			ma = tbt_pkg::edge_t'(job_q.du2);
			mb = job_q.dv1;
		end else begin
			unique case (j[1:0])
				2'd0: begin ma = e1_sel; mb = job_q.dv2; end
				2'd1: begin ma = e2_sel; mb = job_q.dv1; end
				2'd2: begin ma = e2_sel; mb = job_q.du1; end
				2'd3: begin ma = e1_sel; mb = job_q.du2; end
			endcase
		end
	end

	// vector under normalization
	logic signed [55:0] vsrc [3];
	logic [55:0] orv;
	always_comb begin
		for (int i = 0; i < 3; i++) vsrc[i] = vsel_q ? bv_q[i] : tv_q[i];
		orv = mag_q[0] | mag_q[1] | mag_q[2];
	end

	// square root and divide steps
	logic [63:0] trial;
	logic        sq_ge, div_ge;
	logic [16:0] quo_nx;
	logic [16:0] qclamp;
	assign trial  = root_q + bit_q;
	assign sq_ge  = (rad_q >= trial);
	assign div_ge = ({2'b00, num_q} >= dsh_q);
	assign quo_nx = {quo_q[15:0], div_ge};
	assign qclamp = (quo_nx > tbt_pkg::UNIT_Q) ? tbt_pkg::UNIT_Q : quo_nx;

	logic [3:0]  wj;
	logic [1:0]  wi;
	assign wj = 4'(pdst_s1 - 5'd2);
	assign wi = wj[3:2];

	assign job_pop = (state_q == ST_IDLE) && job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pvalid_s1   <= 1'b0;
			res_valid_q <= 1'b0;
			k_q         <= '0;
			vsel_q      <= 1'b0;
			comp_q      <= '0;
			degen_q     <= 1'b0;
			beat_q      <= '0;
			dcnt_q      <= '0;
		end else begin
			pvalid_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						k_q     <= '0;
						vsel_q  <= 1'b0;
						degen_q <= 1'b0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					pvalid_s1 <= 1'b1;
					pdst_s1   <= k_q;
					k_q       <= k_q + 5'd1;
					if (k_q == 5'd13) state_q <= ST_MUL_END;
				end
				ST_MUL_END: begin
					if (det_q == '0) begin
						degen_q <= 1'b1;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= vsrc[i][55] ? 56'(-vsrc[i]) : 56'(vsrc[i]);
						neg_q[i] <= vsrc[i][55] ^ det_q[42];
					end
					if (vsrc[0] == '0 && vsrc[1] == '0 && vsrc[2] == '0) begin
						degen_q <= 1'b1;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					priority if (|orv[55:24]) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 4;
					end else if (|orv[55:20]) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
					end else if (~|orv[19:15]) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 4;
					end else if (!orv[19]) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
					end else begin
						k_q     <= '0;
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					pvalid_s1 <= 1'b1;
					pdst_s1   <= DST_SQ;
					k_q       <= k_q + 5'd1;
					if (k_q == 5'd2) state_q <= ST_SQR_END;
				end
				ST_SQR_END: state_q <= ST_SQRT_INIT;
				ST_SQRT_INIT: begin
					rad_q   <= {2'b00, ssum_q, 20'd0};
					root_q  <= '0;
					bit_q   <= 64'd1 << 62;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (sq_ge) begin
						rad_q  <= rad_q - trial;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						comp_q  <= '0;
						state_q <= ST_DIV_INIT;
					end
				end
				ST_DIV_INIT: begin
					num_q   <= {2'b00, mag_q[comp_q][19:0], 24'd0} + 46'(root_q[30:1]);
					dsh_q   <= {1'b0, root_q[30:0], 16'd0};
					quo_q   <= '0;
					dcnt_q  <= 5'd16;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_ge) num_q <= num_q - dsh_q[45:0];
					quo_q  <= quo_nx;
					dsh_q  <= dsh_q >> 1;
					dcnt_q <= dcnt_q - 5'd1;
					if (dcnt_q == '0) begin
						state_q <= ST_DIV_INIT;
						comp_q  <= comp_q + 2'd1;
						if (comp_q == 2'd2) begin
							vsel_q  <= 1'b1;
							state_q <= vsel_q ? ST_EMIT : ST_SETUP;
						end
					end
				end
				ST_EMIT: begin
					if (!res_valid_q) begin
						res_valid_q <= 1'b1;
						beat_q      <= '0;
					end else if (!res_stall) begin
						beat_q <= beat_q + 2'd1;
						if (beat_q == 2'd2) begin
							res_valid_q <= 1'b0;
							state_q     <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
		if (state_q == ST_IDLE && job_valid) job_q <= job;
		// no product lands while scaling, so the sum clears here
		if (state_q == ST_SCALE) ssum_q <= '0;
		if (pvalid_s1) begin
			if (pdst_s1 == DST_SQ) begin
				ssum_q <= ssum_q + prod_s1[41:0];
			end else if (pdst_s1 == 5'd0) begin
				det_q <= prod_s1[42:0];
			end else if (pdst_s1 == 5'd1) begin
				det_q <= det_q - prod_s1[42:0];
			end else begin
				unique case (wj[1:0])
					2'd0: tv_q[wi] <= 56'(prod_s1);
					2'd1: tv_q[wi] <= tv_q[wi] - 56'(prod_s1);
					2'd2: bv_q[wi] <= 56'(prod_s1);
					2'd3: bv_q[wi] <= bv_q[wi] - 56'(prod_s1);
				endcase
			end
		end
		if (state_q == ST_DIV && dcnt_q == '0) begin
			if (vsel_q) begin
				bres_q[comp_q] <= neg_q[comp_q] ? -tbt_pkg::comp_t'(qclamp)
				                                :  tbt_pkg::comp_t'(qclamp);
			end else begin
				tres_q[comp_q] <= neg_q[comp_q] ? -tbt_pkg::comp_t'(qclamp)
				                                :  tbt_pkg::comp_t'(qclamp);
			end
		end
	end

	assign res_valid        = res_valid_q;
	assign degenerate       = degen_q;
	assign last_of_triangle = (beat_q == 2'd2);
	assign tangent_x        = degen_q ? '0 : tres_q[0];
	assign tangent_y        = degen_q ? '0 : tres_q[1];
	assign tangent_z        = degen_q ? '0 : tres_q[2];
	assign bitangent_x      = degen_q ? '0 : bres_q[0];
	assign bitangent_y      = degen_q ? '0 : bres_q[1];
	assign bitangent_z      = degen_q ? '0 : bres_q[2];

endmodule

[rtl/triangle_tangent_basis_top.sv]
// Per-triangle tangent / bitangent generator.
// Vertex channel (vtx_valid / vtx_stall): one non-indexed vertex per beat,
// position in Q16.16, texture coordinate in Q4.16. Every third beat closes
// a triangle; its edges and UV deltas go into a two-entry job queue.
// Result channel (res_valid / res_stall): three identical beats per triangle,
// unit tangent and bitangent in Q1.14, degenerate flag, last_of_triangle on
// the third beat. Degenerate triangles give zero vectors.
// One shared multiplier does 14 products per triangle and 3 squares per
// vector; each vector takes 1 to 12 scaling steps, a 32-step square root
// and three divides (one per component). The front takes one vertex per
// cycle while the queue has room. vtx_stall is high only when the job queue
// is full. When the receiver holds res_stall, the result beat holds steady
// and the back end waits; the front keeps filling the queue meanwhile.
// Reset (arst_n low) clears the vertex phase, the queue and the sequencer;
// held vertex and datapath registers are not cleared.
module triangle_tangent_basis_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vtx_valid,
	output logic               vtx_stall,
	input  logic signed [31:0] position_x,
	input  logic signed [31:0] position_y,
	input  logic signed [31:0] position_z,
	input  logic signed [19:0] tex_u,
	input  logic signed [19:0] tex_v,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [15:0] tangent_x,
	output logic signed [15:0] tangent_y,
	output logic signed [15:0] tangent_z,
	output logic signed [15:0] bitangent_x,
	output logic signed [15:0] bitangent_y,
	output logic signed [15:0] bitangent_z,
	output logic               degenerate,
	output logic               last_of_triangle
);

	tbt_pkg::job_t push_job, pop_job;
	logic q_full, q_push, q_pop, q_nonempty;

	tbt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.vtx_valid  (vtx_valid),
		.vtx_stall  (vtx_stall),
		.position_x (position_x),
		.position_y (position_y),
		.position_z (position_z),
		.tex_u      (tex_u),
		.tex_v      (tex_v),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (push_job)
	);

	// decouples vertex intake from the normalization sequencer
	tbt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_job),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.pop_data  (pop_job)
	);

	tbt_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.job_valid        (q_nonempty),
		.job              (pop_job),
		.job_pop          (q_pop),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.tangent_x        (tangent_x),
		.tangent_y        (tangent_y),
		.tangent_z        (tangent_z),
		.bitangent_x      (bitangent_x),
		.bitangent_y      (bitangent_y),
		.bitangent_z      (bitangent_z),
		.degenerate       (degenerate),
		.last_of_triangle (last_of_triangle)
	);

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	typedef tbt_pkg::comp_t comp_t;

	// ------------------------------------------------------------------
	// clock, reset, DUT ports
	// ------------------------------------------------------------------
	logic               clk;
	logic               arst_n;
	logic               vtx_valid;
	logic               vtx_stall;
	logic signed [31:0] position_x, position_y, position_z;
	logic signed [19:0] tex_u, tex_v;
	logic               res_valid;
	logic               res_stall;
	comp_t              tangent_x, tangent_y, tangent_z;
	comp_t              bitangent_x, bitangent_y, bitangent_z;
	logic               degenerate;
	logic               last_of_triangle;

	triangle_tangent_basis_top u_top (
		.clk(clk), .arst_n(arst_n),
		.vtx_valid(vtx_valid), .vtx_stall(vtx_stall),
		.position_x(position_x), .position_y(position_y), .position_z(position_z),
		.tex_u(tex_u), .tex_v(tex_v),
		.res_valid(res_valid), .res_stall(res_stall),
		.tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
		.bitangent_x(bitangent_x), .bitangent_y(bitangent_y), .bitangent_z(bitangent_z),
		.degenerate(degenerate), .last_of_triangle(last_of_triangle)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// ------------------------------------------------------------------
	// beat types
	// ------------------------------------------------------------------
	typedef struct packed {
		logic signed [31:0] px, py, pz;
		logic signed [19:0] u, v;
	} vertex_t;

	typedef struct packed {
		comp_t tx, ty, tz, bx, by, bz;
		logic  degen;
		logic  last;
	} basis_t;

	// directed row: the vertex, and for the closing vertex of a triangle
	// optionally a hand-written basis instead of the predicted one
	typedef struct packed {
		vertex_t vtx;
		logic    typed;
		basis_t  basis;
	} row_t;

	basis_t basis_q[$];     // bases still owed by the block
	int     fails;
	logic   hold_req;       // asks the receiver for one long hold-off

	// ------------------------------------------------------------------
	// tangent basis predictor: its own copy of the held vertices
	// ------------------------------------------------------------------
	logic [1:0]         tri_phase;
	logic signed [31:0] hold_p0 [3];
	logic signed [31:0] hold_p1 [3];
	logic signed [19:0] hold_uv0 [2];
	logic signed [19:0] hold_uv1 [2];

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned r, b, x;
		r = 0;
		x = n;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// unit vector in Q1.14; returns 0 for a zero vector
	function automatic bit unit_vec(input longint vx, vy, vz, output comp_t ox, oy, oz);
		longint          v [3];
		longint unsigned mag [3];
		longint unsigned a [3];
		longint unsigned m, s, len, q;
		int              n;
		comp_t           o [3];
		v[0] = vx; v[1] = vy; v[2] = vz;
		m = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
			if (mag[i] > m) m = mag[i];
		end
		ox = '0; oy = '0; oz = '0;
		if (m == 0) return 0;
		n = 0;
		while ((m >> n) != 0) n++;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = (n > 20) ? (mag[i] >> (n - 20)) : (mag[i] << (20 - n));
			s = s + a[i] * a[i];
		end
		len = int_sqrt(s << 20);
		for (int i = 0; i < 3; i++) begin
			q = ((a[i] << 24) + (len >> 1)) / len;
			if (q > 64'd16384) q = 64'd16384;
			o[i] = (v[i] < 0) ? comp_t'(-longint'(q)) : comp_t'(q);
		end
		ox = o[0]; oy = o[1]; oz = o[2];
		return 1;
	endfunction

	// takes one vertex; returns 1 when it closes a triangle, with its basis
	function automatic bit tri_vertex(input vertex_t vt, output basis_t bs);
		longint e1 [3];
		longint e2 [3];
		longint p2 [3];
		longint t [3];
		longint b [3];
		longint du1, dv1, du2, dv2, det;
		bit     okt, okb;
		bs = '0;
		p2[0] = vt.px; p2[1] = vt.py; p2[2] = vt.pz;
		if (tri_phase == 2'd1) begin
			hold_p1[0] = vt.px; hold_p1[1] = vt.py; hold_p1[2] = vt.pz;
			hold_uv1[0] = vt.u; hold_uv1[1] = vt.v;
			tri_phase = 2'd2;
			return 0;
		end
		if (tri_phase != 2'd2) begin
			hold_p0[0] = vt.px; hold_p0[1] = vt.py; hold_p0[2] = vt.pz;
			hold_uv0[0] = vt.u; hold_uv0[1] = vt.v;
			tri_phase = 2'd1;
			return 0;
		end
		tri_phase = 2'd0;
		for (int i = 0; i < 3; i++) begin
			e1[i] = longint'(hold_p1[i]) - longint'(hold_p0[i]);
			e2[i] = p2[i] - longint'(hold_p0[i]);
		end
		du1 = longint'(hold_uv1[0]) - longint'(hold_uv0[0]);
		dv1 = longint'(hold_uv1[1]) - longint'(hold_uv0[1]);
		du2 = longint'(vt.u) - longint'(hold_uv0[0]);
		dv2 = longint'(vt.v) - longint'(hold_uv0[1]);
		det = du1 * dv2 - du2 * dv1;
		for (int i = 0; i < 3; i++) begin
			t[i] = dv2 * e1[i] - dv1 * e2[i];
			b[i] = du1 * e2[i] - du2 * e1[i];
			if (det < 0) begin
				t[i] = -t[i];
				b[i] = -b[i];
			end
		end
		bs.degen = (det == 0);
		if (!bs.degen) begin
			okt = unit_vec(t[0], t[1], t[2], bs.tx, bs.ty, bs.tz);
			okb = unit_vec(b[0], b[1], b[2], bs.bx, bs.by, bs.bz);
			bs.degen = !(okt && okb);
		end
		if (bs.degen) begin
			bs.tx = '0; bs.ty = '0; bs.tz = '0;
			bs.bx = '0; bs.by = '0; bs.bz = '0;
		end
		return 1;
	endfunction

	// ------------------------------------------------------------------
	// vertex sender: gaps are mostly short, a few long
	// ------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// offers one beat from the falling edge; returns just after the
	// falling edge that follows acceptance, with valid still high
	task automatic send_vertex(input vertex_t vt, input logic typed, input basis_t want);
		int     gap;
		basis_t bs;
		gap = pick_gap();
		if (gap > 0) begin
			vtx_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		position_x <= vt.px; position_y <= vt.py; position_z <= vt.pz;
		tex_u <= vt.u; tex_v <= vt.v;
		vtx_valid <= 1'b1;
		do @(posedge clk); while (vtx_stall);
		if (tri_vertex(vt, bs)) begin
			if (typed) bs = want;
			for (int k = 0; k < 3; k++) begin
				bs.last = (k == 2);
				basis_q.push_back(bs);
			end
		end
		@(negedge clk);
	endtask

	// sender waits for every owed basis, plus a settle time
	task automatic drain();
		vtx_valid <= 1'b0;
		@(negedge clk);
		while (basis_q.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	function automatic vertex_t rand_vertex(input int mode);
		vertex_t vt;
		vt.u = 20'($urandom);
		vt.v = 20'($urandom);
		if (mode == 0) begin
			// modest coordinates, well inside Q16.16
			vt.px = 32'($signed($urandom_range(0, 2097151)) - 1048576);
			vt.py = 32'($signed($urandom_range(0, 2097151)) - 1048576);
			vt.pz = 32'($signed($urandom_range(0, 2097151)) - 1048576);
		end else begin
			vt.px = $urandom; vt.py = $urandom; vt.pz = $urandom;
		end
		return vt;
	endfunction

	// ------------------------------------------------------------------
	// directed table
	// ------------------------------------------------------------------
	localparam int ONE_P = 65536;   // 1.0 in Q16.16
	localparam int ONE_T = 65536;   // 1.0 in Q4.16
	localparam logic signed [31:0] PMAX = 32'h7fffffff;
	localparam logic signed [31:0] PMIN = 32'h80000000;
	localparam logic signed [19:0] TMAX = 20'h7ffff;
	localparam logic signed [19:0] TMIN = 20'h80000;

	localparam basis_t B_NONE  = '0;
	localparam basis_t B_DEGEN = '{tx: 0, ty: 0, tz: 0, bx: 0, by: 0, bz: 0,
		degen: 1'b1, last: 1'b0};
	localparam basis_t B_AXIS  = '{tx: 16384, ty: 0, tz: 0, bx: 0, by: 16384, bz: 0,
		degen: 1'b0, last: 1'b0};

	localparam int N_ROWS = 18;
	row_t table_rows [N_ROWS];

	initial begin
		// axis-aligned triangle, uv matches xy: tangent +x, bitangent +y
		table_rows[0]  = '{'{0, 0, 0, 0, 0}, 1'b0, B_NONE};
		table_rows[1]  = '{'{ONE_P, 0, 0, ONE_T, 0}, 1'b0, B_NONE};
		table_rows[2]  = '{'{0, ONE_P, 0, 0, ONE_T}, 1'b1, B_AXIS};
		// all uv equal: zero determinant
		table_rows[3]  = '{'{5, 6, 7, 100, 100}, 1'b0, B_NONE};
		table_rows[4]  = '{'{ONE_P, 9, 3, 100, 100}, 1'b0, B_NONE};
		table_rows[5]  = '{'{2, ONE_P, 8, 100, 100}, 1'b1, B_DEGEN};
		// all positions equal: zero-length vectors
		table_rows[6]  = '{'{PMAX, PMIN, 77, 0, 0}, 1'b0, B_NONE};
		table_rows[7]  = '{'{PMAX, PMIN, 77, ONE_T, 0}, 1'b0, B_NONE};
		table_rows[8]  = '{'{PMAX, PMIN, 77, 0, ONE_T}, 1'b1, B_DEGEN};
		// field extremes, largest edges and uv deltas
		table_rows[9]  = '{'{PMIN, PMIN, PMIN, TMIN, TMIN}, 1'b0, B_NONE};
		table_rows[10] = '{'{PMAX, PMAX, PMIN, TMAX, TMIN}, 1'b0, B_NONE};
		table_rows[11] = '{'{PMAX, PMIN, PMAX, TMIN, TMAX}, 1'b0, B_NONE};
		// swapped uv: negative determinant flips both vectors
		table_rows[12] = '{'{0, 0, 0, 0, 0}, 1'b0, B_NONE};
		table_rows[13] = '{'{ONE_P, 0, 0, 0, ONE_T}, 1'b0, B_NONE};
		table_rows[14] = '{'{0, ONE_P, 0, ONE_T, 0}, 1'b0, B_NONE};
		// tiny edges: left shift in normalization
		table_rows[15] = '{'{-3, 1, 0, -5, 2}, 1'b0, B_NONE};
		table_rows[16] = '{'{-2, 1, 1, -4, 2}, 1'b0, B_NONE};
		table_rows[17] = '{'{-3, 2, 0, -5, 3}, 1'b0, B_NONE};
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin
		vertex_t tv [3];
		int      r, mode;
		arst_n = 1'b0;
		vtx_valid = 1'b0;
		position_x = '0; position_y = '0; position_z = '0;
		tex_u = '0; tex_v = '0;
		hold_req = 1'b0;
		fails = 0;
		tri_phase = 2'd0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_ROWS; i++)
			send_vertex(table_rows[i].vtx, table_rows[i].typed, table_rows[i].basis);

		for (int n = 0; n < 120; n++) begin
			// long receiver hold-off while vertices keep coming: queue fills
			if (n == 30) hold_req = 1'b1;
			// sender pause until every owed basis has come
			if (n == 80) drain();
			r = $urandom_range(0, 99);
			mode = (r < 45) ? 0 : 1;
			for (int k = 0; k < 3; k++) tv[k] = rand_vertex(mode);
			if (r >= 70 && r < 80) begin
				// shared uv: zero determinant
				tv[1].u = tv[0].u; tv[1].v = tv[0].v;
				tv[2].u = tv[0].u; tv[2].v = tv[0].v;
			end else if (r >= 80 && r < 86) begin
				// shared position: zero-length vectors
				tv[1].px = tv[0].px; tv[1].py = tv[0].py; tv[1].pz = tv[0].pz;
				tv[2].px = tv[0].px; tv[2].py = tv[0].py; tv[2].pz = tv[0].pz;
			end else if (r >= 86 && r < 92) begin
				// collinear uv
				tv[1].u = tv[0].u + 20'sd16; tv[1].v = tv[0].v + 20'sd16;
				tv[2].u = tv[0].u + 20'sd32; tv[2].v = tv[0].v + 20'sd32;
			end
			for (int k = 0; k < 3; k++) send_vertex(tv[k], 1'b0, B_NONE);
		end

		drain();
		if (fails == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// ------------------------------------------------------------------
	// result receiver: random stall runs, one long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		int run, r;
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_stall <= 1'b1;
				repeat (3000) @(negedge clk);
				hold_req = 1'b0;
				res_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 30) begin
					// open stretch
					res_stall <= 1'b0;
					run = $urandom_range(5, 40);
				end else begin
					res_stall <= (r < 65);
					run = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60);
				end
				repeat (run - 1) @(negedge clk);
			end
		end
	end

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------
	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		fails++;
	endtask

	always @(posedge clk) begin
		basis_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (basis_q.size() == 0) begin
				report("unexpected beat", 1, 0);
			end else begin
				want = basis_q.pop_front();
				if (tangent_x !== want.tx) report("tangent_x", tangent_x, want.tx);
				if (tangent_y !== want.ty) report("tangent_y", tangent_y, want.ty);
				if (tangent_z !== want.tz) report("tangent_z", tangent_z, want.tz);
				if (bitangent_x !== want.bx) report("bitangent_x", bitangent_x, want.bx);
				if (bitangent_y !== want.by) report("bitangent_y", bitangent_y, want.by);
				if (bitangent_z !== want.bz) report("bitangent_z", bitangent_z, want.bz);
				if (degenerate !== want.degen) report("degenerate", degenerate, want.degen);
				if (last_of_triangle !== want.last)
					report("last_of_triangle", last_of_triangle, want.last);
			end
		end
	end

	// watchdog: cycles with no beat on either channel
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((vtx_valid && !vtx_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("tb: failure");
			$finish;
		end
	end

endmodule
